/* hdl/frr_pkg.sv */
package frr_pkg;

    localparam logic [1:0] MODE_SERIAL   = 2'd0;
    localparam logic [1:0] MODE_TICK     = 2'd1;
    localparam logic [1:0] MODE_POLL     = 2'd2;
    localparam logic [1:0] MODE_SET_IDLE = 2'd3;

    localparam logic [7:0] RESET_MARKER    = 8'h5A;
    localparam logic [7:0] RESET_IDLE_RATE = 8'd12;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic       host_ready;
    } frr_item_t;

    typedef struct packed {
        logic [7:0] third_axis;
        logic [7:0] second_axis;
        logic [7:0] first_axis;
        logic [7:0] buttons;
    } frr_report_t;

endpackage

/* hdl/frr_if.sv */
interface frr_in_if;
    import frr_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       host_ready;

    modport source (output valid, output mode, output data_byte, output host_ready,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input host_ready,
                    output ready);
endinterface

interface frr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] buttons;
    logic [7:0] first_axis;
    logic [7:0] second_axis;
    logic [7:0] third_axis;

    modport source (output valid, output buttons, output first_axis,
                    output second_axis, output third_axis, input ready);
    modport sink   (input valid, input buttons, input first_axis,
                    input second_axis, input third_axis, output ready);
endinterface

/* hdl/frr_core.sv */
module frr_core
    import frr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  frr_item_t   item,
    input  logic [7:0]  frame_marker,
    output logic        emit,
    output frr_report_t report
);

    localparam logic [2:0] POS_WAIT = 3'd0;
    localparam logic [2:0] POS_X    = 3'd1;
    localparam logic [2:0] POS_Y    = 3'd2;
    localparam logic [2:0] POS_Z    = 3'd3;
    localparam logic [2:0] POS_B    = 3'd4;

    logic [2:0]  pos_reg,     pos_next;
    logic [7:0]  held_x_reg,  held_x_next;
    logic [7:0]  held_y_reg,  held_y_next;
    logic [7:0]  held_z_reg,  held_z_next;
    logic [31:0] built_reg,   built_next;
    logic [31:0] sent_reg,    sent_next;
    logic        pending_reg, pending_next;
    logic [7:0]  count_reg,   count_next;
    logic [7:0]  rate_reg,    rate_next;

    logic [2:0]  pos_mid;
    logic [7:0]  count_inc;
    logic        pend_poll;

    always_comb
    begin
        pos_next     = pos_reg;
        held_x_next  = held_x_reg;
        held_y_next  = held_y_reg;
        held_z_next  = held_z_reg;
        built_next   = built_reg;
        sent_next    = sent_reg;
        pending_next = pending_reg;
        count_next   = count_reg;
        rate_next    = rate_reg;
        emit         = 1'b0;
        pos_mid      = pos_reg;
        count_inc    = count_reg + 8'd1;
        pend_poll    = pending_reg || (built_reg != sent_reg);

        case (item.mode)
            MODE_SERIAL:
            begin
                case (pos_reg)
                    POS_WAIT: pos_mid = POS_WAIT;
                    POS_X:
                    begin
                        held_x_next = item.data_byte;
                        pos_mid     = POS_Y;
                    end
                    POS_Y:
                    begin
                        held_y_next = item.data_byte;
                        pos_mid     = POS_Z;
                    end
                    POS_Z:
                    begin
                        held_z_next = item.data_byte;
                        pos_mid     = POS_B;
                    end
                    default:
                    begin
                        // last frame byte, or an unreachable code: close the frame
                        built_next = {held_z_reg, held_y_reg, held_x_reg, item.data_byte};
                        pos_mid    = POS_WAIT;
                    end
                endcase
                // a marker that closes a frame also opens the next one
                if ((item.data_byte == frame_marker) && (pos_mid == POS_WAIT))
                    pos_next = POS_X;
                else
                    pos_next = pos_mid;
            end
            MODE_TICK:
            begin
                if (count_inc >= rate_reg)
                begin
                    count_next   = 8'd0;
                    pending_next = 1'b1;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            MODE_SET_IDLE:
            begin
                rate_next = item.data_byte;
            end
            default:
            begin
                if (pend_poll && item.host_ready)
                begin
                    pending_next = 1'b0;
                    sent_next    = built_reg;
                    emit         = 1'b1;
                end
                else
                begin
                    pending_next = pend_poll;
                end
            end
        endcase

        if (!step)
            emit = 1'b0;
    end

    assign report = frr_report_t'(built_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_WAIT;
            held_x_reg  <= 8'd0;
            held_y_reg  <= 8'd0;
            held_z_reg  <= 8'd0;
            built_reg   <= 32'd0;
            sent_reg    <= 32'd0;
            pending_reg <= 1'b0;
            count_reg   <= 8'd0;
            rate_reg    <= RESET_IDLE_RATE;
        end
        else if (step)
        begin
            pos_reg     <= pos_next;
            held_x_reg  <= held_x_next;
            held_y_reg  <= held_y_next;
            held_z_reg  <= held_z_next;
            built_reg   <= built_next;
            sent_reg    <= sent_next;
            pending_reg <= pending_next;
            count_reg   <= count_next;
            rate_reg    <= rate_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_B)
        else $error("frame position out of range");

    a_emit_poll: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (step && item.mode == MODE_POLL && item.host_ready))
        else $error("report sent on a non-poll item");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (!pending_reg && sent_reg == $past(built_reg)))
        else $error("sent report not recorded");

endmodule

/* hdl/framed_report_relay_top.sv */
// Path: a poll beat is accepted into the input register, and its report is
// loaded into the result register when the input register advances.
// Throughput: one item per cycle; the input register advances whenever the
// result register is empty or being drained.
// Reset: rst_n asynchronous, active low; clears the valid flags and the core
// state (not the data registers), marker 0x5A, idle rate 12.
module framed_report_relay_top
    import frr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    frr_in_if.sink      req,
    frr_out_if.source   rpt,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  marker_reg;
    logic        stage_valid_reg;
    frr_item_t   stage_reg;
    logic        out_valid_reg;
    frr_report_t out_reg;

    logic        advance;
    logic        emit;
    frr_report_t report;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, marker_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            marker_reg <= RESET_MARKER;
        else if (psel && penable && pwrite && !paddr[2])
            marker_reg <= pwdata[7:0];
    end

    assign advance   = stage_valid_reg && (!out_valid_reg || rpt.ready);
    assign req.ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (req.ready)
            stage_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            stage_reg <= '{mode: req.mode, data_byte: req.data_byte,
                           host_ready: req.host_ready};
    end

    frr_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (stage_reg),
        .frame_marker (marker_reg),
        .emit         (emit),
        .report       (report)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (rpt.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_reg <= report;
    end

    assign rpt.valid       = out_valid_reg;
    assign rpt.buttons     = out_reg.buttons;
    assign rpt.first_axis  = out_reg.first_axis;
    assign rpt.second_axis = out_reg.second_axis;
    assign rpt.third_axis  = out_reg.third_axis;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || rpt.ready))
        else $error("result register overwritten before its beat");

    a_rose_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(emit))
        else $error("result valid without an emitted report");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |=> (stage_valid_reg && $stable(stage_reg)))
        else $error("stalled item lost");

endmodule
